/* rtl/ksf_pkg.sv */
// ----------------------------------------------------------------------------
// ksf_pkg
// Shared types, constants and the scancode translation for the keyboard FIFO.
// ----------------------------------------------------------------------------
package ksf_pkg;

    localparam logic ACTION_KEY  = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    localparam logic [79:0] ROW_TOP    = "qwertyuiop";
    localparam logic [71:0] ROW_HOME   = "asdfghjkl";
    localparam logic [55:0] ROW_BOTTOM = "zxcvbnm";

    localparam logic [6:0] CHAR_ZERO    = 7'h30;
    localparam logic [6:0] CHAR_ONE     = 7'h31;
    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
    localparam logic [6:0] CHAR_SPACE   = 7'h20;
    localparam logic [6:0] CHAR_DOT     = 7'h2E;
    localparam logic [6:0] CHAR_SLASH   = 7'h2F;
    localparam logic [6:0] CHAR_NONE    = 7'h00;

    typedef struct packed {
        logic       action;
        logic [7:0] scancode;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic       char_valid;
        logic       dropped;
        logic [8:0] fill_level;
    } out_item_t;

    typedef struct packed {
        logic is_read;
        logic sc_zero;
        logic full;
        logic empty;
    } ksf_status_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic load_imm;
        logic load_mem;
    } ksf_cmd_t;

    function automatic logic [6:0] translate(input logic [7:0] sc);
        logic [7:0] ofs;
        logic [6:0] ch;
        ch = CHAR_NONE;
        if (sc inside {[8'h10:8'h19]}) begin
            ofs = sc - 8'h10;
            ch  = ROW_TOP[8 * (9 - ofs[3:0]) +: 7];
        end else if (sc inside {[8'h1E:8'h26]}) begin
            ofs = sc - 8'h1E;
            ch  = ROW_HOME[8 * (8 - ofs[3:0]) +: 7];
        end else if (sc inside {[8'h2C:8'h32]}) begin
            ofs = sc - 8'h2C;
            ch  = ROW_BOTTOM[8 * (6 - ofs[2:0]) +: 7];
        end else if (sc inside {[8'h02:8'h0A]}) begin
            ofs = sc - 8'h02;
            ch  = CHAR_ONE + 7'(ofs[3:0]);
        end else if (sc == 8'h0B) begin
            ch = CHAR_ZERO;
        end else if (sc inside {8'h1C, 8'h0E}) begin
            ch = CHAR_NEWLINE;
        end else if (sc == 8'h39) begin
            ch = CHAR_SPACE;
        end else if (sc == 8'h34) begin
            ch = CHAR_DOT;
        end else if (sc == 8'h35) begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

/* rtl/keyboard_scancode_fifo.sv */
// ----------------------------------------------------------------------------
// keyboard_scancode_fifo
// Set-1 scancode to ASCII translation feeding a character FIFO.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): action 0 is a key event that
// translates the scancode and pushes the character; scancode zero or a full
// FIFO drops the event and sets dropped. Action 1 pops the oldest character,
// or returns char_valid low when the FIFO is empty.
// Output channel (out_valid/out_ready/out_data): one result per transfer,
// carrying the fill level after that item.
// Key events and empty reads load the result register from the transfer;
// a read that pops first reads the registered read port of the character
// store, then loads the result; in_ready is low in the read-wait between.
// Throughput: one key event per cycle, unless out_ready holds the output.
// A new transfer is taken while the previous result is being taken in the
// same cycle; while out_ready stays low with a result held, in_ready is low.
// Reset empties the FIFO (pointers and count cleared); store contents are
// not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module keyboard_scancode_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ksf_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ksf_pkg::out_item_t out_data
);
    import ksf_pkg::*;

    ksf_status_t status;
    ksf_cmd_t    cmd;

    ksf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ksf_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

/* rtl/ksf_ram.sv */
// ----------------------------------------------------------------------------
// ksf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ksf_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ksf_ctrl.sv */
// ----------------------------------------------------------------------------
// ksf_ctrl
// Controller: handshakes, read-wait state and output valid.
// ----------------------------------------------------------------------------
module ksf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  ksf_pkg::ksf_status_t status,
    output ksf_pkg::ksf_cmd_t    cmd
);
    import ksf_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.push     = accept && !status.is_read && !status.sc_zero && !status.full;
        cmd.pop      = accept && status.is_read && !status.empty;
        cmd.load_imm = accept && !(status.is_read && !status.empty);
        cmd.load_mem = (state_reg == S_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.pop)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_imm || cmd.load_mem)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> !out_valid_reg)
        else $error("read data returning while output register is occupied");

    a_read_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid_reg)
        else $error("read result not presented after memory access");

    a_pop_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (state_reg == S_READ))
        else $error("pop did not enter read state");

    a_no_double_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_imm && cmd.load_mem))
        else $error("two result loads in one cycle");
`endif

endmodule

/* rtl/ksf_datapath.sv */
// ----------------------------------------------------------------------------
// ksf_datapath
// Datapath: translation, character store, pointers, count and result register.
// ----------------------------------------------------------------------------
module ksf_datapath #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ksf_pkg::in_item_t    in_data,
    input  ksf_pkg::ksf_cmd_t    cmd,
    output ksf_pkg::ksf_status_t status,
    output ksf_pkg::out_item_t   out_data
);
    import ksf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_W = $bits(out_data.fill_level);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    out_item_t        out_reg, out_next;
    logic [6:0]       rdata;

    assign status.is_read = (in_data.action == ACTION_READ);
    assign status.sc_zero = (in_data.scancode == 8'h00);
    assign status.full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign status.empty   = (count_reg == '0);

    ksf_ram #(
        .WIDTH (7),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (wr_ptr_reg),
        .wdata (translate(in_data.scancode)),
        .re    (cmd.pop),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (cmd.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_imm)
        begin
            out_next.char_out   = CHAR_NONE;
            out_next.char_valid = 1'b0;
            out_next.dropped    = !status.is_read && !cmd.push;
            out_next.fill_level = FILL_W'(count_next);
        end
        else if (cmd.load_mem)
        begin
            out_next.char_out   = rdata;
            out_next.char_valid = 1'b1;
            out_next.dropped    = 1'b0;
            out_next.fill_level = FILL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("held count exceeds depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(FIFO_DEPTH)) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("pointers disagree with held count");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop))
        else $error("push and pop in the same cycle");
`endif

endmodule

/* verif/keyboard_scancode_fifo_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_scancode_fifo_tb
// Self-checking bench for the scancode translator and character FIFO.
// A directed table walks every key row, the translation extremes, unmapped
// codes, zero scancodes and empty reads. Random phases then fill the FIFO
// past full, starting with one long receiver hold-off, drain part of it and mix both.
// Each result transfer is checked field by field against an in-bench model
// of the FIFO or, for rows marked by hand, against the table's own values.
// ----------------------------------------------------------------------------
module keyboard_scancode_fifo_tb;

    import ksf_pkg::*;

    localparam int       DEPTH    = 256;
    localparam bit       BY_HAND  = 1'b1;
    localparam bit       BY_MODEL = 1'b0;
    localparam int       HOLD_OFF = 80;

    typedef struct packed {
        logic       action;
        logic [7:0] scancode;
        logic       by_hand;
        out_item_t  exp;
    } stim_row_t;

    stim_row_t key_table [26] = '{
        {ACTION_READ, 8'h00, BY_HAND,  7'h00, 1'b0, 1'b0, 9'd0},
        {ACTION_KEY,  8'h00, BY_HAND,  7'h00, 1'b0, 1'b1, 9'd0},
        {ACTION_READ, 8'hFF, BY_HAND,  7'h00, 1'b0, 1'b0, 9'd0},
        {ACTION_KEY,  8'h10, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h19, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h1E, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h26, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h2C, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h32, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h02, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h0A, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h0B, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h1C, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h0E, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h39, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h34, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h35, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'hFF, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h01, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h80, BY_MODEL, 18'h0},
        {ACTION_KEY,  8'h00, BY_HAND,  7'h00, 1'b0, 1'b1, 9'd17},
        {ACTION_READ, 8'h00, BY_MODEL, 18'h0},
        {ACTION_READ, 8'hFF, BY_MODEL, 18'h0},
        {ACTION_READ, 8'h55, BY_MODEL, 18'h0},
        {ACTION_READ, 8'hAA, BY_MODEL, 18'h0},
        {ACTION_READ, 8'h10, BY_MODEL, 18'h0}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    string keys_top    = "qwertyuiop";
    string keys_home   = "asdfghjkl";
    string keys_bottom = "zxcvbnm";
    string keys_digit  = "1234567890";

    logic [6:0] char_mem [DEPTH];
    logic [7:0] rd_ptr = '0;
    logic [7:0] wr_ptr = '0;
    logic [8:0] held   = '0;

    out_item_t expected_results [$];

    int transfers_in   = 0;
    int results_out    = 0;
    int mismatch_count = 0;
    int pops           = 0;
    int empty_reads    = 0;
    int full_drops     = 0;
    int zero_drops     = 0;
    int unmapped       = 0;
    int burst_left     = 0;

    logic hold_req  = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;
    int   rx_phase  = 0;

    keyboard_scancode_fifo uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [6:0] scancode_to_ascii(input logic [7:0] sc);
        logic [6:0] ch;
        ch = 7'h00;
        if (sc >= 8'h10 && sc <= 8'h19)
            ch = 7'(keys_top[sc - 8'h10]);
        else if (sc >= 8'h1E && sc <= 8'h26)
            ch = 7'(keys_home[sc - 8'h1E]);
        else if (sc >= 8'h2C && sc <= 8'h32)
            ch = 7'(keys_bottom[sc - 8'h2C]);
        else if (sc >= 8'h02 && sc <= 8'h0B)
            ch = 7'(keys_digit[sc - 8'h02]);
        else
            case (sc)
                8'h1C, 8'h0E: ch = 7'h0A;
                8'h39:        ch = 7'h20;
                8'h34:        ch = 7'h2E;
                8'h35:        ch = 7'h2F;
                default:      ch = 7'h00;
            endcase
        return ch;
    endfunction

    task automatic predict_result(input in_item_t it, output out_item_t res);
        res = '0;
        if (it.action == ACTION_KEY)
        begin
            if (it.scancode == 8'h00)
            begin
                res.dropped = 1'b1;
                zero_drops++;
            end
            else if (held == 9'(DEPTH))
            begin
                res.dropped = 1'b1;
                full_drops++;
            end
            else
            begin
                char_mem[wr_ptr] = scancode_to_ascii(it.scancode);
                if (char_mem[wr_ptr] == 7'h00)
                    unmapped++;
                wr_ptr++;
                held++;
            end
        end
        else if (held != 0)
        begin
            res.char_out   = char_mem[rd_ptr];
            res.char_valid = 1'b1;
            rd_ptr++;
            held--;
            pops++;
        end
        else
            empty_reads++;
        res.fill_level = held;
    endtask

    function automatic in_item_t random_item(input int key_pct);
        in_item_t it;
        int pick;
        pick        = $urandom_range(0, 99);
        it.scancode = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < key_pct)
        begin
            it.action = ACTION_KEY;
            if (pick < 4)
                it.scancode = 8'h00;
            else if (pick < 74)
                it.scancode = 8'($urandom_range(1, 8'h39));
        end
        else
            it.action = ACTION_READ;
        return it;
    endfunction

    // bursts of transfers separated by random gaps; a zero gap keeps valid high
    task automatic send_item(input in_item_t it, input bit by_hand, input out_item_t hand_res);
        out_item_t res;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_result(it, res);
        expected_results.push_back(by_hand ? hand_res : res);
        transfers_in++;
    endtask

    task automatic send_random(input int key_pct);
        send_item(random_item(key_pct), BY_MODEL, '0);
    endtask

    function automatic void check_field(input string name, input int exp, input int got);
        if (exp != got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t exp;
        if (expected_results.size() == 0)
        begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            exp = expected_results.pop_front();
            check_field("char_out",   exp.char_out,   got.char_out);
            check_field("char_valid", exp.char_valid, got.char_valid);
            check_field("dropped",    exp.dropped,    got.dropped);
            check_field("fill_level", exp.fill_level, got.fill_level);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_result(out_data);
            results_out++;
        end
    end

    // receiver: free-running stall pattern, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_OFF;
            hold_done <= 1'b1;
        end
        else
        begin
            rx_phase  <= (rx_phase + 1) % 64;
            out_ready <= (rx_phase < 20) ||
                         (($urandom_range(0, 3) != 0) && (rx_phase % 9 != 4));
        end
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        in_item_t it;
        in_valid = 1'b0;
        in_data  = '0;
        rst_n    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        for (int i = 0; i < 26; i++)
        begin
            it.action   = key_table[i].action;
            it.scancode = key_table[i].scancode;
            send_item(it, key_table[i].by_hand, key_table[i].exp);
        end

        // fill past full, starting with one long receiver hold-off
        hold_req <= 1'b1;
        while (full_drops < 20)
            send_random(97);

        // drain part way, then mix pushes and pops
        repeat (60) send_random(5);

        repeat (70) send_random(50);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Transfers: %0d in, %0d out; %0d pops, %0d empty reads, %0d unmapped stored",
                 transfers_in, results_out, pops, empty_reads, unmapped);
        $display("Drops: %0d on full FIFO, %0d zero scancodes; %0d mismatches",
                 full_drops, zero_drops, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
